[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define SBDA_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked property that is also checked during reset
`define SBDA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

[rtl/sbda_pkg.sv]
// types and constants of the binary to decimal ascii converter
package sbda_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned DIGITS_N  = 10;
  localparam int unsigned DIG_IDX_W = $clog2(DIGITS_N);
  localparam int unsigned PROD_W    = 2 * VALUE_W;
  localparam int unsigned RECIP_SH  = 35;
  localparam int unsigned QUOT_W    = PROD_W - RECIP_SH;

  // ceil(2^35 / 10): exact quotient by ten for any 32-bit magnitude
  localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic quot_zero;
    logic idx_zero;
    logic neg;
    logic out_free;
  } sts_t;

endpackage

[rtl/sbda_in_if.sv]
// request channel carrying one signed integer
interface sbda_in_if;
  import sbda_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[rtl/sbda_out_if.sv]
// result channel carrying one ascii character
interface sbda_out_if;
  import sbda_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

[rtl/sbda_ctrl.sv]
// controller state machine of the converter
module sbda_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sbda_pkg::sts_t sts_i,
  output sbda_pkg::cmd_t cmd_o
);
  import sbda_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.quot_zero) begin
          state_d = sts_i.neg ? ST_SIGN : ST_DIGIT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_SIGN: begin
        if (sts_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.idx_zero) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/sbda_dpath.sv]
// datapath: magnitude, divide by ten, digit store and output register
module sbda_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sbda_pkg::cmd_t                      cmd_i,
  output sbda_pkg::sts_t                      sts_o,
  input  logic signed [sbda_pkg::VALUE_W-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [sbda_pkg::CHAR_W-1:0]         char_code_o,
  output logic                                last_char_o
);
  import sbda_pkg::*;

  logic                 neg_q;
  logic [VALUE_W-1:0]   mag_q;
  logic [PROD_W-1:0]    prod_q;
  logic [DIG_IDX_W-1:0] nd_q;
  logic [DIG_IDX_W-1:0] idx_q;
  logic [DIGIT_W-1:0]   digit_q [DIGITS_N];
  logic                 out_valid_q;
  logic [CHAR_W-1:0]    char_q;
  logic                 last_q;

  logic [QUOT_W-1:0]    quot;
  logic [DIGIT_W-1:0]   rem;
  logic [VALUE_W-1:0]   value_u;

  assign value_u = value_i;
  assign quot    = prod_q[PROD_W-1:RECIP_SH];
  // remainder < 10, so the low four bits of mag - 10*quot are exact
  assign rem     = mag_q[DIGIT_W-1:0] - {quot[0], 3'b000} - {quot[DIGIT_W-2:0], 1'b0};

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= value_u[VALUE_W-1];
      mag_q <= value_u[VALUE_W-1] ? (~value_u + VALUE_W'(1)) : value_u;
    end else if (cmd_i.step) begin
      mag_q <= VALUE_W'(quot);
    end
    if (cmd_i.mul) begin
      prod_q <= mag_q * RECIP_TEN;
    end
    if (cmd_i.step) begin
      digit_q[nd_q] <= rem;
    end
    if (cmd_i.emit_sign) begin
      char_q <= CHAR_MINUS;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= CHAR_ZERO + CHAR_W'(digit_q[idx_q]);
      last_q <= (idx_q == '0);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_q        <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        nd_q <= '0;
      end else if (cmd_i.step) begin
        nd_q  <= nd_q + DIG_IDX_W'(1);
        idx_q <= nd_q;
      end
      if (cmd_i.emit_digit) begin
        idx_q <= idx_q - DIG_IDX_W'(1);
      end
      if (cmd_i.emit_sign || cmd_i.emit_digit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.quot_zero = (quot == '0);
  assign sts_o.idx_zero  = (idx_q == '0);
  assign sts_o.neg       = neg_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule

[rtl/signed_binary_to_decimal_ascii_unit.sv]
// top level: signed 32-bit integer to decimal ascii character stream
// each request runs the divide-by-ten loop once per digit (1..10 digits), then
// emits an optional minus sign (negative values only) and the digits through
// the output register, one character per cycle while the sink is ready;
// a sink stall holds both the waiting character and the controller
// reset (rst_ni low, asynchronous) returns the controller to idle and drops out valid
module signed_binary_to_decimal_ascii_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  sbda_in_if.sink         req_i,
  sbda_out_if.source      res_o
);
  import sbda_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller: idle -> (multiply, divide) per digit -> optional sign -> digits
  sbda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: digits come out least significant first from the divide loop,
  // are parked in a small digit store and read back most significant first;
  // the output register lets the next request start while the final
  // character still waits on the sink
  sbda_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_i     (req_i.value),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .char_code_o (res_o.char_code),
    .last_char_o (res_o.last_char)
  );

endmodule

[rtl/sbda_checker.sv]
// port-level checks of the converter and their bind
`include "assert_macros.svh"

module sbda_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [sbda_pkg::CHAR_W-1:0] char_code_i,
  input logic                        last_char_i
);
  import sbda_pkg::*;

  `SBDA_ASSERT_RST(a_reset_no_valid, !rst_ni |-> !out_valid_i, "out valid during reset")
  `SBDA_ASSERT_CLK(a_stall_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(char_code_i) && $stable(last_char_i), "stalled character changed")
  `SBDA_ASSERT_CLK(a_char_legal, out_valid_i |-> (char_code_i == CHAR_MINUS) || (char_code_i >= CHAR_ZERO && char_code_i <= CHAR_NINE), "illegal character")
  `SBDA_ASSERT_CLK(a_sign_not_last, out_valid_i && char_code_i == CHAR_MINUS |-> !last_char_i, "minus sign ends a run")

endmodule

bind signed_binary_to_decimal_ascii_unit sbda_checker u_sbda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .char_code_i (res_o.char_code),
  .last_char_i (res_o.last_char)
);
